[design/rmsd_pkg.sv]
// rmsd_pkg: shared types, widths and codes for the running mean / std dev block
// no dependencies; used by every module under design/

package rmsd_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 16;
  localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
  localparam int SQ_BITS     = 2 * SAMPLE_BITS + COUNT_BITS - 2;
  localparam int NUM_BITS    = 64;
  localparam int DEN_BITS    = 2 * COUNT_BITS;
  localparam int VAR_BITS    = 31;
  localparam int ROOT_BITS   = 16;
  localparam int STEP_BITS   = 7;
  localparam int FIFO_DEPTH  = 2;
  localparam int PTR_BITS    = $clog2(FIFO_DEPTH);

  // operand split for the shared 32x24 multiplier
  localparam int MUL_B_BITS  = 24;
  localparam int SQ_LO_BITS  = SQ_BITS / 2;
  localparam int SUM_LO_BITS = SUM_BITS / 2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX     = '1;
  localparam logic [COUNT_BITS-1:0] MIN_VAR_COUNT = COUNT_BITS'(2);
  localparam logic [VAR_BITS-1:0]   VAR_MAX       = '1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          start_new;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0]         sample_count;
    logic signed [SAMPLE_BITS-1:0] mean_value;
    logic [VAR_BITS-1:0]           variance;
    logic [ROOT_BITS-1:0]          std_dev;
    logic                          count_full;
  } out_item_t;

  // accumulator snapshot handed from front to back
  typedef struct packed {
    logic [COUNT_BITS-1:0]      count;
    logic signed [SUM_BITS-1:0] sum;
    logic [SQ_BITS-1:0]         sq;
    logic                       full;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [2:0] {
    BACK_IDLE,
    BACK_MUL,
    BACK_NUM,
    BACK_DIV_START,
    BACK_DIV,
    BACK_ROOT,
    BACK_HOLD
  } back_state_e;

  typedef enum logic [1:0] {
    MUL_N_LO,
    MUL_N_HI,
    MUL_S_LO,
    MUL_S_HI
  } mul_phase_e;

endpackage

[design/running_mean_std_dev.sv]
// running_mean_std_dev: top level, running mean and sample standard deviation
// depends on rmsd_pkg, rmsd_front, rmsd_fifo and rmsd_back (rmsd_div via rmsd_back)
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------
//   in      | input     | in_valid_i / in_ready_o | in_item_i  (sample, start_new)
//   out     | output    | out_valid_o/out_ready_i | out_item_o (count, mean, var, sd)
//
// the back end runs a 64-step variance division (one quotient bit a cycle),
//   plus 4 multiply steps and 16 square root steps; the mean division runs
//   alongside the variance one
// the front updates the accumulators in the cycle a request is taken and
//   queues a snapshot, so up to two further requests land while the back works
// reset clears the accumulators, queue pointers and the result valid at once
// a stalled output holds its result; the back then waits to unload, the
//   queue fills and in_ready_o falls

module running_mean_std_dev (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rmsd_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rmsd_pkg::out_item_t out_item_o
);

  // snapshot queue between accumulate and compute
  rmsd_pkg::fifo_stat_t fifo_stat;
  rmsd_pkg::entry_t     push_entry;
  rmsd_pkg::entry_t     head_entry;
  logic                 push;
  logic                 pop;

  // front: accepts samples, handles start_new and count saturation
  rmsd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  rmsd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head_entry),
    .stat_o  (fifo_stat)
  );

  // back: products, divisions, square root and the output register
  rmsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_stat_i (fifo_stat),
    .entry_i     (head_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

[design/rmsd_fifo.sv]
// rmsd_fifo: short queue of accumulator snapshots between front and back
// depends on rmsd_pkg

module rmsd_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  rmsd_pkg::entry_t     entry_i,
  input  logic                 pop_i,
  output rmsd_pkg::entry_t     head_o,
  output rmsd_pkg::fifo_stat_t stat_o
);

  rmsd_pkg::entry_t                mem_q [rmsd_pkg::FIFO_DEPTH];
  logic [rmsd_pkg::PTR_BITS-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [rmsd_pkg::PTR_BITS:0]     cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == rmsd_pkg::PTR_BITS'(rmsd_pkg::FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == rmsd_pkg::PTR_BITS'(rmsd_pkg::FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  assign head_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == (rmsd_pkg::PTR_BITS + 1)'(rmsd_pkg::FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !stat_o.full)
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !stat_o.empty)
    else $error("pop from empty queue");

endmodule

[design/rmsd_front.sv]
// rmsd_front: takes samples, updates sum, sum of squares and count
// depends on rmsd_pkg; pushes one snapshot per request into rmsd_fifo

module rmsd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rmsd_pkg::in_item_t   in_item_i,
  input  rmsd_pkg::fifo_stat_t fifo_stat_i,
  output logic                 push_o,
  output rmsd_pkg::entry_t     entry_o
);

  logic signed [rmsd_pkg::SUM_BITS-1:0]   sum_q, sum_d, base_sum;
  logic [rmsd_pkg::SQ_BITS-1:0]           sq_q, sq_d, base_sq;
  logic [rmsd_pkg::COUNT_BITS-1:0]        count_q, count_d, base_count;
  logic [rmsd_pkg::SAMPLE_BITS-1:0]       mag;
  logic [2*rmsd_pkg::SAMPLE_BITS-1:0]     square;
  logic                                   full;
  logic                                   accept;

  assign in_ready_o = !fifo_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    base_sum   = in_item_i.start_new ? '0 : sum_q;
    base_sq    = in_item_i.start_new ? '0 : sq_q;
    base_count = in_item_i.start_new ? '0 : count_q;
    full       = (base_count == rmsd_pkg::COUNT_MAX);
    mag        = in_item_i.sample[rmsd_pkg::SAMPLE_BITS-1] ?
                 (~in_item_i.sample + 1'b1) : in_item_i.sample;
    square     = mag * mag;
    sum_d      = base_sum;
    sq_d       = base_sq;
    count_d    = base_count;
    if (!full) begin
      sum_d   = base_sum + {{(rmsd_pkg::SUM_BITS - rmsd_pkg::SAMPLE_BITS)
                            {in_item_i.sample[rmsd_pkg::SAMPLE_BITS-1]}}, in_item_i.sample};
      sq_d    = base_sq + rmsd_pkg::SQ_BITS'(square);
      count_d = base_count + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      sq_q    <= '0;
      count_q <= '0;
    end else if (accept) begin
      sum_q   <= sum_d;
      sq_q    <= sq_d;
      count_q <= count_d;
    end
  end

  assign push_o        = accept;
  assign entry_o.count = count_d;
  assign entry_o.sum   = sum_d;
  assign entry_o.sq    = sq_d;
  assign entry_o.full  = full;

endmodule

[design/rmsd_div.sv]
// rmsd_div: restoring divider, one quotient bit per cycle
// depends on rmsd_pkg; the dividend sits msb-first in a shift register

module rmsd_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [rmsd_pkg::STEP_BITS-1:0]   steps_i,
  input  logic [rmsd_pkg::NUM_BITS-1:0]    dividend_i,
  input  logic [rmsd_pkg::DEN_BITS-1:0]    divisor_i,
  output logic                             busy_o,
  output logic [rmsd_pkg::NUM_BITS-1:0]    quotient_o
);

  logic [rmsd_pkg::DEN_BITS-1:0]   rem_q, rem_d;
  logic [rmsd_pkg::DEN_BITS:0]     trial;
  logic [rmsd_pkg::NUM_BITS-1:0]   shift_q, shift_d;
  logic [rmsd_pkg::DEN_BITS-1:0]   den_q, den_d;
  logic [rmsd_pkg::STEP_BITS-1:0]  left_q, left_d;
  logic                            busy_q, busy_d;
  logic                            fits;

  always_comb begin
    trial   = {rem_q, shift_q[rmsd_pkg::NUM_BITS-1]};
    fits    = (trial >= {1'b0, den_q});
    rem_d   = rem_q;
    shift_d = shift_q;
    den_d   = den_q;
    left_d  = left_q;
    busy_d  = busy_q;
    if (start_i) begin
      rem_d   = '0;
      shift_d = dividend_i;
      den_d   = divisor_i;
      left_d  = steps_i;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      // the remainder stays below the divisor, so it fits the divisor's width
      rem_d   = fits ? rmsd_pkg::DEN_BITS'(trial - {1'b0, den_q})
                     : trial[rmsd_pkg::DEN_BITS-1:0];
      shift_d = {shift_q[rmsd_pkg::NUM_BITS-2:0], fits};
      left_d  = left_q - 1'b1;
      busy_d  = (left_q != rmsd_pkg::STEP_BITS'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      left_q <= '0;
    end else begin
      busy_q <= busy_d;
      left_q <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    shift_q <= shift_d;
    den_q   <= den_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = shift_q;

endmodule

[design/rmsd_back.sv]
// rmsd_back: turns one snapshot into mean, variance and std dev, holds the result
// depends on rmsd_pkg and rmsd_div (two instances: mean and variance)

module rmsd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rmsd_pkg::fifo_stat_t fifo_stat_i,
  input  rmsd_pkg::entry_t     entry_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rmsd_pkg::out_item_t  out_item_o
);

  localparam logic [rmsd_pkg::VAR_BITS:0] ROOT_TOP =
    {2'b01, {(rmsd_pkg::VAR_BITS - 1){1'b0}}};

  rmsd_pkg::back_state_e                  state_q, state_d;
  rmsd_pkg::mul_phase_e                   phase_q, phase_d;
  rmsd_pkg::entry_t                       cur_q, cur_d;
  rmsd_pkg::out_item_t                    out_q, out_d;
  logic                                   out_valid_q, out_valid_d;
  logic [rmsd_pkg::SUM_BITS-1:0]          mag_q, mag_d;
  logic [rmsd_pkg::NUM_BITS-1:0]          lhs_q, lhs_d, rhs_q, rhs_d, num_q, num_d;
  logic [rmsd_pkg::DEN_BITS-1:0]          den_q, den_d;
  logic [rmsd_pkg::VAR_BITS-1:0]          var_q, var_d;
  logic [rmsd_pkg::SAMPLE_BITS-1:0]       mean_q, mean_d, mean_mag;
  logic [rmsd_pkg::VAR_BITS:0]            x_q, x_d, root_q, root_d, bit_q, bit_d, root_try;
  logic [rmsd_pkg::COUNT_BITS-1:0]        count_m1;
  logic [rmsd_pkg::SUM_BITS-1:0]          mul_a;
  logic [rmsd_pkg::MUL_B_BITS-1:0]        mul_b;
  logic [rmsd_pkg::SUM_BITS+rmsd_pkg::MUL_B_BITS-1:0] mul_p;
  logic                                   div_start, mean_busy, var_busy, divs_done;
  logic [rmsd_pkg::NUM_BITS-1:0]          mean_quo, var_quo;
  logic                                   can_load;

  rmsd_div u_mean_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .steps_i    (rmsd_pkg::STEP_BITS'(rmsd_pkg::SUM_BITS)),
    .dividend_i ({mag_q, {(rmsd_pkg::NUM_BITS - rmsd_pkg::SUM_BITS){1'b0}}}),
    .divisor_i  (rmsd_pkg::DEN_BITS'(cur_q.count)),
    .busy_o     (mean_busy),
    .quotient_o (mean_quo)
  );

  rmsd_div u_var_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .steps_i    (rmsd_pkg::STEP_BITS'(rmsd_pkg::NUM_BITS)),
    .dividend_i (num_q),
    .divisor_i  (den_q),
    .busy_o     (var_busy),
    .quotient_o (var_quo)
  );

  assign divs_done = !mean_busy && !var_busy;
  assign can_load  = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rmsd_pkg::BACK_IDLE: begin
        if (!fifo_stat_i.empty) state_d = rmsd_pkg::BACK_MUL;
      end
      rmsd_pkg::BACK_MUL: begin
        if (phase_q == rmsd_pkg::MUL_S_HI) state_d = rmsd_pkg::BACK_NUM;
      end
      rmsd_pkg::BACK_NUM:       state_d = rmsd_pkg::BACK_DIV_START;
      rmsd_pkg::BACK_DIV_START: state_d = rmsd_pkg::BACK_DIV;
      rmsd_pkg::BACK_DIV: begin
        if (divs_done) state_d = rmsd_pkg::BACK_ROOT;
      end
      rmsd_pkg::BACK_ROOT: begin
        if (bit_q == '0) state_d = rmsd_pkg::BACK_HOLD;
      end
      rmsd_pkg::BACK_HOLD: begin
        if (can_load) state_d = rmsd_pkg::BACK_IDLE;
      end
      default: state_d = rmsd_pkg::BACK_IDLE;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = mag_q;
    mul_b = '0;
    case (phase_q)
      rmsd_pkg::MUL_N_LO: begin
        mul_a = rmsd_pkg::SUM_BITS'(cur_q.count);
        mul_b = rmsd_pkg::MUL_B_BITS'(cur_q.sq[rmsd_pkg::SQ_LO_BITS-1:0]);
      end
      rmsd_pkg::MUL_N_HI: begin
        mul_a = rmsd_pkg::SUM_BITS'(cur_q.count);
        mul_b = rmsd_pkg::MUL_B_BITS'(cur_q.sq[rmsd_pkg::SQ_BITS-1:rmsd_pkg::SQ_LO_BITS]);
      end
      rmsd_pkg::MUL_S_LO: begin
        mul_b = rmsd_pkg::MUL_B_BITS'(mag_q[rmsd_pkg::SUM_LO_BITS-1:0]);
      end
      rmsd_pkg::MUL_S_HI: begin
        mul_b = rmsd_pkg::MUL_B_BITS'(mag_q[rmsd_pkg::SUM_BITS-1:rmsd_pkg::SUM_LO_BITS]);
      end
      default: mul_b = '0;
    endcase
    mul_p = mul_a * mul_b;
  end

  // datapath and outputs
  always_comb begin
    cur_d       = cur_q;
    mag_d       = mag_q;
    phase_d     = phase_q;
    lhs_d       = lhs_q;
    rhs_d       = rhs_q;
    num_d       = num_q;
    den_d       = den_q;
    var_d       = var_q;
    mean_d      = mean_q;
    x_d         = x_q;
    root_d      = root_q;
    bit_d       = bit_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pop_o       = 1'b0;
    div_start   = 1'b0;
    count_m1    = cur_q.count - 1'b1;
    mean_mag    = mean_quo[rmsd_pkg::SAMPLE_BITS-1:0];
    root_try    = root_q + bit_q;
    case (state_q)
      rmsd_pkg::BACK_IDLE: begin
        if (!fifo_stat_i.empty) begin
          pop_o   = 1'b1;
          cur_d   = entry_i;
          mag_d   = entry_i.sum[rmsd_pkg::SUM_BITS-1] ?
                    rmsd_pkg::SUM_BITS'(-entry_i.sum) : rmsd_pkg::SUM_BITS'(entry_i.sum);
          phase_d = rmsd_pkg::MUL_N_LO;
        end
      end
      rmsd_pkg::BACK_MUL: begin
        case (phase_q)
          rmsd_pkg::MUL_N_LO: begin
            lhs_d   = rmsd_pkg::NUM_BITS'(mul_p);
            den_d   = cur_q.count * count_m1;
            phase_d = rmsd_pkg::MUL_N_HI;
          end
          rmsd_pkg::MUL_N_HI: begin
            lhs_d   = lhs_q + (rmsd_pkg::NUM_BITS'(mul_p) << rmsd_pkg::SQ_LO_BITS);
            phase_d = rmsd_pkg::MUL_S_LO;
          end
          rmsd_pkg::MUL_S_LO: begin
            rhs_d   = rmsd_pkg::NUM_BITS'(mul_p);
            phase_d = rmsd_pkg::MUL_S_HI;
          end
          rmsd_pkg::MUL_S_HI: begin
            rhs_d   = rhs_q + (rmsd_pkg::NUM_BITS'(mul_p) << rmsd_pkg::SUM_LO_BITS);
            phase_d = rmsd_pkg::MUL_N_LO;
          end
          default: phase_d = rmsd_pkg::MUL_N_LO;
        endcase
      end
      rmsd_pkg::BACK_NUM: begin
        // clamp at zero when n*sumsq does not exceed sum^2
        num_d = (lhs_q > rhs_q) ? (lhs_q - rhs_q) : '0;
      end
      rmsd_pkg::BACK_DIV_START: begin
        div_start = 1'b1;
      end
      rmsd_pkg::BACK_DIV: begin
        if (divs_done) begin
          if (cur_q.count < rmsd_pkg::MIN_VAR_COUNT) begin
            var_d = '0;
          end else if (var_quo > rmsd_pkg::NUM_BITS'(rmsd_pkg::VAR_MAX)) begin
            var_d = rmsd_pkg::VAR_MAX;
          end else begin
            var_d = var_quo[rmsd_pkg::VAR_BITS-1:0];
          end
          mean_d = cur_q.sum[rmsd_pkg::SUM_BITS-1] ? (~mean_mag + 1'b1) : mean_mag;
          x_d    = {1'b0, var_d};
          root_d = '0;
          bit_d  = ROOT_TOP;
        end
      end
      rmsd_pkg::BACK_ROOT: begin
        if (bit_q != '0) begin
          if (x_q >= root_try) begin
            x_d    = x_q - root_try;
            root_d = (root_q >> 1) + bit_q;
          end else begin
            root_d = root_q >> 1;
          end
          bit_d = bit_q >> 2;
        end
      end
      rmsd_pkg::BACK_HOLD: begin
        if (can_load) begin
          out_d.sample_count = cur_q.count;
          out_d.mean_value   = mean_q;
          out_d.variance     = var_q;
          out_d.std_dev      = root_q[rmsd_pkg::ROOT_BITS-1:0];
          out_d.count_full   = cur_q.full;
          out_valid_d        = 1'b1;
        end
      end
      default: out_d = out_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rmsd_pkg::BACK_IDLE;
      phase_q     <= rmsd_pkg::MUL_N_LO;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    mag_q  <= mag_d;
    lhs_q  <= lhs_d;
    rhs_q  <= rhs_d;
    num_q  <= num_d;
    den_q  <= den_d;
    var_q  <= var_d;
    mean_q <= mean_d;
    x_q    <= x_d;
    root_q <= root_d;
    bit_q  <= bit_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rmsd_pkg::BACK_ROOT) |-> $onehot0(bit_q))
    else $error("root bit lost its single set position");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rmsd_pkg::BACK_DIV_START) |=> (mean_busy && var_busy))
    else $error("dividers did not start together");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.sample_count < rmsd_pkg::MIN_VAR_COUNT)) |-> (out_q.variance == '0))
    else $error("nonzero variance below two samples");

endmodule
